// ===== design/mecanum_wheel_mixer_macros.svh =====
// Assertion macros used by the mecanum wheel mixer module.
`ifndef MECANUM_WHEEL_MIXER_MACROS_SVH
`define MECANUM_WHEEL_MIXER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MWM_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define MWM_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mwm_pkg.sv =====
// Types and constants shared by the mecanum wheel mixer modules.
`default_nettype none

package mwm_pkg;

   localparam int InW           = 16;
   localparam int MixW          = 19;   // three 16-bit terms summed
   localparam int MagW          = 17;   // magnitude of a mixed sum
   localparam int RemW          = MagW + 1;
   localparam int QuoW          = 15;   // normalized magnitude, at most 16384
   localparam int Lanes         = 4;
   localparam int StepsPerStage = 3;
   localparam int DivStages     = QuoW / StepsPerStage;
   localparam int OneFixed      = 16384;

   // Wheel lane order.
   localparam int LaneLf = 0;
   localparam int LaneLr = 1;
   localparam int LaneRf = 2;
   localparam int LaneRr = 3;

   typedef logic signed [InW-1:0]  fix_type;
   typedef logic signed [MixW-1:0] mix_type;
   typedef logic [MagW-1:0]        mag_type;
   typedef logic [RemW-1:0]        rem_type;
   typedef logic [QuoW-1:0]        quo_type;

   typedef struct packed {
      fix_type strafe;
      fix_type forward;
      fix_type turn;
   } req_type;

   typedef struct packed {
      fix_type lf_speed;
      fix_type lr_speed;
      fix_type rf_speed;
      fix_type rr_speed;
   } rsp_type;

   // Payload of the normalizing divider pipeline.
   typedef struct packed {
      mag_type                  peak;
      logic                     bypass;
      logic [Lanes-1:0]         neg;
      quo_type [Lanes-1:0]      pass;
      rem_type [Lanes-1:0]      rem;
      quo_type [Lanes-1:0]      quo;
   } div_type;

endpackage

`default_nettype wire

// ===== design/mecanum_wheel_mixer.sv =====
// Mecanum wheel mixer: mixes a drive command into four normalized wheel speeds.
//
//   channel  | direction | handshake               | beat
//   ---------+-----------+-------------------------+-------------------------------
//   req      | in        | req_valid / req_ready   | strafe, forward, turn
//   rsp      | out       | rsp_valid / rsp_ready   | lf_speed .. rr_speed
//
// A beat passes through mix, magnitude, peak, five divider stages of three quotient
// bits each, and the output register. One beat enters each cycle unless rsp stalls.
// Each stage holds its own valid bit and advances when the next one is free,
// so bubbles collapse and a stall at rsp holds every stage without loss.
// Synchronous reset clears the valid bits only.
`default_nettype none

`include "mecanum_wheel_mixer_macros.svh"

module mecanum_wheel_mixer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mwm_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mwm_pkg::rsp_type  rsp_data
);

   localparam int Lanes = mwm_pkg::Lanes;
   localparam int Nd    = mwm_pkg::DivStages;

   // Stage 1: mixed sums.
   logic                              s1_vld_ff;
   logic                              s1_vld_in;
   logic                              s1_adv;
   mwm_pkg::mix_type [Lanes-1:0]      s1_mix_ff;
   mwm_pkg::mix_type [Lanes-1:0]      s1_mix_in;
   mwm_pkg::mix_type                  x_ext;
   mwm_pkg::mix_type                  y_ext;
   mwm_pkg::mix_type                  r_ext;

   // Stage 2: sign and magnitude.
   logic                              s2_vld_ff;
   logic                              s2_vld_in;
   logic                              s2_adv;
   logic [Lanes-1:0]                  s2_neg_ff;
   logic [Lanes-1:0]                  s2_neg_in;
   mwm_pkg::mag_type [Lanes-1:0]      s2_mag_ff;
   mwm_pkg::mag_type [Lanes-1:0]      s2_mag_in;

   // Stage 3: peak and divider setup.
   logic                              s3_vld_ff;
   logic                              s3_vld_in;
   logic                              s3_adv;
   mwm_pkg::div_type                  s3_ff;
   mwm_pkg::div_type                  s3_in;
   mwm_pkg::mag_type                  peak_a;
   mwm_pkg::mag_type                  peak_b;
   mwm_pkg::mag_type                  peak;

   // Divider chain.
   logic                              div_vld [Nd+1];
   logic                              div_rdy [Nd+1];
   mwm_pkg::div_type                  div_data [Nd+1];

   // Output register.
   logic                              rsp_vld_ff;
   logic                              rsp_vld_in;
   mwm_pkg::rsp_type                  rsp_ff;
   mwm_pkg::rsp_type                  rsp_in;
   mwm_pkg::fix_type [Lanes-1:0]      wheel;
   mwm_pkg::quo_type                  val;
   logic [mwm_pkg::InW-1:0]           val_ext;

   // Ready chain, from the output back to the input.
   assign div_rdy[Nd] = !rsp_vld_ff || rsp_ready;
   assign s3_adv      = !s3_vld_ff || div_rdy[0];
   assign s2_adv      = !s2_vld_ff || s3_adv;
   assign s1_adv      = !s1_vld_ff || s2_adv;
   assign req_ready   = s1_adv;

   // ---- stage 1 ----
   always_comb begin
      x_ext = mwm_pkg::MixW'(req_data.strafe);
      y_ext = mwm_pkg::MixW'(req_data.forward);
      r_ext = mwm_pkg::MixW'(req_data.turn);
      s1_mix_in[mwm_pkg::LaneLf] =  x_ext + y_ext + r_ext;
      s1_mix_in[mwm_pkg::LaneLr] = -x_ext + y_ext + r_ext;
      s1_mix_in[mwm_pkg::LaneRf] = -x_ext + y_ext - r_ext;
      s1_mix_in[mwm_pkg::LaneRr] =  x_ext + y_ext - r_ext;
   end

   assign s1_vld_in = s1_adv ? req_valid : s1_vld_ff;

   always_ff @(posedge clock) begin
      if (s1_adv && req_valid) begin
         s1_mix_ff <= s1_mix_in;
      end
   end

   // ---- stage 2 ----
   always_comb begin
      for (int l = 0; l < Lanes; l++) begin
         s2_neg_in[l] = s1_mix_ff[l][mwm_pkg::MixW-1];
         s2_mag_in[l] = s2_neg_in[l] ? mwm_pkg::MagW'(-s1_mix_ff[l])
                                     : mwm_pkg::MagW'(s1_mix_ff[l]);
      end
   end

   assign s2_vld_in = s2_adv ? s1_vld_ff : s2_vld_ff;

   always_ff @(posedge clock) begin
      if (s2_adv && s1_vld_ff) begin
         s2_neg_ff <= s2_neg_in;
         s2_mag_ff <= s2_mag_in;
      end
   end

   // ---- stage 3 ----
   always_comb begin
      peak_a = (s2_mag_ff[0] > s2_mag_ff[1]) ? s2_mag_ff[0] : s2_mag_ff[1];
      peak_b = (s2_mag_ff[2] > s2_mag_ff[3]) ? s2_mag_ff[2] : s2_mag_ff[3];
      peak   = (peak_a > peak_b) ? peak_a : peak_b;
      s3_in.peak   = peak;
      // Leave the sums as they are when no wheel exceeds full scale.
      s3_in.bypass = (peak <= mwm_pkg::MagW'(mwm_pkg::OneFixed));
      s3_in.neg    = s2_neg_ff;
      for (int l = 0; l < Lanes; l++) begin
         s3_in.pass[l] = mwm_pkg::QuoW'(s2_mag_ff[l]);
         s3_in.rem[l]  = mwm_pkg::RemW'(s2_mag_ff[l]);
         s3_in.quo[l]  = '0;
      end
   end

   assign s3_vld_in = s3_adv ? s2_vld_ff : s3_vld_ff;

   always_ff @(posedge clock) begin
      if (s3_adv && s2_vld_ff) begin
         s3_ff <= s3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
      end
   end

   // ---- divider ----
   assign div_vld[0]  = s3_vld_ff;
   assign div_data[0] = s3_ff;

   for (genvar k = 0; k < Nd; k++) begin : g_div
      mwm_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_vld[k]),
         .in_data   (div_data[k]),
         .in_ready  (div_rdy[k]),
         .out_valid (div_vld[k+1]),
         .out_data  (div_data[k+1]),
         .out_ready (div_rdy[k+1])
      );
   end

   // ---- output ----
   always_comb begin
      val     = '0;
      val_ext = '0;
      for (int l = 0; l < Lanes; l++) begin
         val     = div_data[Nd].bypass ? div_data[Nd].pass[l] : div_data[Nd].quo[l];
         val_ext = mwm_pkg::InW'(val);
         wheel[l] = div_data[Nd].neg[l] ? mwm_pkg::fix_type'(-val_ext)
                                        : mwm_pkg::fix_type'(val_ext);
      end
      rsp_in.lf_speed = wheel[mwm_pkg::LaneLf];
      rsp_in.lr_speed = wheel[mwm_pkg::LaneLr];
      rsp_in.rf_speed = wheel[mwm_pkg::LaneRf];
      rsp_in.rr_speed = wheel[mwm_pkg::LaneRr];
   end

   assign rsp_vld_in = div_rdy[Nd] ? div_vld[Nd] : rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_rdy[Nd] && div_vld[Nd]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // ---- assertions ----
   `MWM_CHECK(a_rsp_bounded,
      !rsp_valid ||
      (rsp_data.lf_speed <= mwm_pkg::OneFixed && rsp_data.lf_speed >= -mwm_pkg::OneFixed &&
       rsp_data.lr_speed <= mwm_pkg::OneFixed && rsp_data.lr_speed >= -mwm_pkg::OneFixed &&
       rsp_data.rf_speed <= mwm_pkg::OneFixed && rsp_data.rf_speed >= -mwm_pkg::OneFixed &&
       rsp_data.rr_speed <= mwm_pkg::OneFixed && rsp_data.rr_speed >= -mwm_pkg::OneFixed),
      "wheel speed outside full scale")

   `MWM_CHECK(a_peak_covers,
      !s3_vld_ff ||
      (s3_ff.rem[0] <= mwm_pkg::RemW'(s3_ff.peak) && s3_ff.rem[1] <= mwm_pkg::RemW'(s3_ff.peak) &&
       s3_ff.rem[2] <= mwm_pkg::RemW'(s3_ff.peak) && s3_ff.rem[3] <= mwm_pkg::RemW'(s3_ff.peak)),
      "peak below a lane magnitude")

   `MWM_CHECK_NEXT(a_mix_hold, s1_vld_ff && !s2_adv,
      s1_vld_ff && $stable(s1_mix_ff), "mix stage lost or changed a stalled beat")

endmodule

`default_nettype wire

// ===== design/mwm_div_stage.sv =====
// One register stage of the four-lane restoring divider used for normalization.
`default_nettype none

module mwm_div_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  mwm_pkg::div_type  in_data,
   output logic              in_ready,
   output logic              out_valid,
   output mwm_pkg::div_type  out_data,
   input  logic              out_ready
);

   logic              vld_ff;
   logic              vld_in;
   mwm_pkg::div_type  data_ff;
   mwm_pkg::div_type  data_in;
   mwm_pkg::rem_type  rem;
   mwm_pkg::rem_type  dvs;
   mwm_pkg::quo_type  quo;
   logic              take;

   assign in_ready = !vld_ff || out_ready;

   // Each step: compare, subtract when it fits, shift the remainder left.
   always_comb begin
      data_in = in_data;
      dvs     = mwm_pkg::RemW'(in_data.peak);
      rem     = '0;
      quo     = '0;
      take    = 1'b0;
      for (int l = 0; l < mwm_pkg::Lanes; l++) begin
         rem = in_data.rem[l];
         quo = in_data.quo[l];
         for (int s = 0; s < mwm_pkg::StepsPerStage; s++) begin
            take = (rem >= dvs);
            if (take) begin
               rem = rem - dvs;
            end
            rem = {rem[mwm_pkg::RemW-2:0], 1'b0};
            quo = {quo[mwm_pkg::QuoW-2:0], take};
         end
         data_in.rem[l] = rem;
         data_in.quo[l] = quo;
      end
   end

   assign vld_in = in_ready ? in_valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire
